// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// File: hdl/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, constants, microcode table and character helpers for the
// integer to padded ASCII converter.
// ----------------------------------------------------------------------------
package ita_pkg;

	localparam int MAX_WIDTH_DEF = 63;
	localparam int NDIG          = 11;
	localparam int NDIG_W        = $clog2(NDIG + 1);
	localparam int PC_W          = 4;

	localparam logic [1:0] RADIX_DEC  = 2'd0;
	localparam logic [1:0] RADIX_OCT  = 2'd1;
	localparam logic [1:0] RADIX_HEX  = 2'd2;
	localparam logic [1:0] RADIX_RSVD = 2'd3;

	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ALPHA = 8'h61;

	localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] STEP_MUL    = 4'd1;
	localparam logic [PC_W-1:0] STEP_DIV    = 4'd2;
	localparam logic [PC_W-1:0] STEP_SETUP  = 4'd3;
	localparam logic [PC_W-1:0] STEP_LEADSP = 4'd4;
	localparam logic [PC_W-1:0] STEP_SIGN   = 4'd5;
	localparam logic [PC_W-1:0] STEP_ZEROS  = 4'd6;
	localparam logic [PC_W-1:0] STEP_DIGITS = 4'd7;
	localparam logic [PC_W-1:0] STEP_TRAIL  = 4'd8;

	typedef enum logic [2:0] {OP_WAIT, OP_MUL, OP_DIV, OP_SETUP, OP_EMIT} op_t;
	typedef enum logic [1:0] {SRC_SPACE, SRC_ZERO, SRC_SIGN, SRC_DIGIT} src_t;
	typedef enum logic [2:0] {EN_ALWAYS, EN_LEADSP, EN_ZPAD, EN_SIGN, EN_LEFT} en_t;
	typedef enum logic [1:0] {CNT_PAD, CNT_ONE, CNT_DIGITS} cnt_t;
	typedef enum logic [1:0] {J_NONE, J_QUOT_NZ, J_ALWAYS} jmp_t;

	typedef struct packed {
		op_t             op;
		src_t            src;
		en_t             en;
		cnt_t            cnt;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctl_t;

	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{op: OP_WAIT, src: SRC_SPACE, en: EN_ALWAYS, cnt: CNT_ONE,
			jmp: J_NONE, target: STEP_WAIT};
		case (pc)
			STEP_WAIT:   w.op = OP_WAIT;
			STEP_MUL:    w.op = OP_MUL;
			STEP_DIV: begin
				w.op     = OP_DIV;
				w.jmp    = J_QUOT_NZ;
				w.target = STEP_MUL;
			end
			STEP_SETUP:  w.op = OP_SETUP;
			STEP_LEADSP: begin
				w.op  = OP_EMIT;
				w.src = SRC_SPACE;
				w.en  = EN_LEADSP;
				w.cnt = CNT_PAD;
			end
			STEP_SIGN: begin
				w.op  = OP_EMIT;
				w.src = SRC_SIGN;
				w.en  = EN_SIGN;
				w.cnt = CNT_ONE;
			end
			STEP_ZEROS: begin
				w.op  = OP_EMIT;
				w.src = SRC_ZERO;
				w.en  = EN_ZPAD;
				w.cnt = CNT_PAD;
			end
			STEP_DIGITS: begin
				w.op  = OP_EMIT;
				w.src = SRC_DIGIT;
				w.cnt = CNT_DIGITS;
			end
			STEP_TRAIL: begin
				w.op     = OP_EMIT;
				w.src    = SRC_SPACE;
				w.en     = EN_LEFT;
				w.cnt    = CNT_PAD;
				w.jmp    = J_ALWAYS;
				w.target = STEP_WAIT;
			end
			default: begin
				w.jmp    = J_ALWAYS;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0, d};
		end else begin
			c = CH_ALPHA + {4'b0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

// File: hdl/ita_digit.sv
// ----------------------------------------------------------------------------
// ita_digit
// One radix digit step: quotient and remainder of a 32-bit magnitude by
// 10, 8 or 16. Decimal uses a registered reciprocal product.
// ----------------------------------------------------------------------------
module ita_digit (
	input  logic        clk,
	input  logic        load,
	input  logic [1:0]  radix_sel,
	input  logic [31:0] mag,
	output logic [31:0] quot,
	output logic [3:0]  digit
);
	import ita_pkg::*;

	logic [63:0] prod_s1;
	logic [28:0] q10;
	logic [31:0] q10x10;
	logic [31:0] rem10;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= 64'(mag) * 64'(RECIP10);
		end
	end

	always_comb begin
		q10    = prod_s1[63:35];
		q10x10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
		rem10  = mag - q10x10;
		case (radix_sel)
			RADIX_OCT: begin
				quot  = {3'b000, mag[31:3]};
				digit = {1'b0, mag[2:0]};
			end
			RADIX_HEX: begin
				quot  = {4'b0000, mag[31:4]};
				digit = mag[3:0];
			end
			default: begin
				quot  = {3'b000, q10};
				digit = rem10[3:0];
			end
		endcase
	end

endmodule

// File: hdl/integer_to_padded_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_padded_ascii
// printf-style conversion of a signed 32-bit integer to a padded ASCII field.
// ----------------------------------------------------------------------------
// One word in carries a value, a radix, a field width and the zero pad,
// force plus and left justify flags; the block then sends the formatted
// characters one per word, tlast on the final one. A microcoded sequencer
// steps a small datapath: each digit passes the multiply and divide steps in
// the digit unit (reciprocal multiply for decimal, shift for octal and hex),
// then come a setup step and the format phases that send the characters;
// a format phase that is skipped is still stepped through, and two to four
// of them are skipped for each word. The next word is accepted once the
// last character is handed to the output register.
module integer_to_padded_ascii #(
	parameter int MAX_WIDTH = ita_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// value[31:0], radix_select[33:32], field_width[40:34], zero_pad[41],
	// plus_flag[42], left_flag[43], zero fill [47:44]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_char[7:0]
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast
);
	import ita_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [PC_W-1:0]    pc_q;
	logic [31:0]        mag_q;
	logic               neg_q;
	logic               sign_q;
	logic               zpad_q;
	logic               left_q;
	logic [1:0]         radix_q;
	logic [6:0]         width_q;
	logic [NDIG_W-1:0]  nd_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rem_q;
	logic [3:0]         dig_q [NDIG];
	logic               m_valid_q;
	logic [7:0]         m_data_q;
	logic               m_last_q;

	ctl_t               cw;
	logic               s_fire;
	logic               en;
	logic               cnt_nz;
	logic               phase_end;
	logic               active;
	logic               can_emit;
	logic               emit_fire;
	logic               advance;
	logic               take_jump;
	logic [PC_W-1:0]    pc_next;
	logic [31:0]        quot;
	logic [3:0]         digit;
	logic [3:0]         rd_dig;
	logic [7:0]         ch;
	logic [CW-1:0]      wsat;
	logic [CW-1:0]      len;
	logic [31:0]        in_val;

	ita_digit u_digit (
		.clk       (clk),
		.load      (cw.op == OP_MUL),
		.radix_sel (radix_q),
		.mag       (mag_q),
		.quot      (quot),
		.digit     (digit)
	);

	assign s_axis_tready = (pc_q == STEP_WAIT);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign in_val        = s_axis_tdata[31:0];

	always_comb begin
		cw = ucode(pc_q);
		case (cw.en)
			EN_LEADSP: en = !left_q && !zpad_q;
			EN_ZPAD:   en = !left_q && zpad_q;
			EN_SIGN:   en = sign_q;
			EN_LEFT:   en = left_q;
			default:   en = 1'b1;
		endcase
		case (cw.cnt)
			CNT_PAD: begin
				cnt_nz    = (cnt_q != '0);
				phase_end = (cnt_q == CW'(1));
			end
			CNT_DIGITS: begin
				cnt_nz    = (nd_q != '0);
				phase_end = (nd_q == NDIG_W'(1));
			end
			default: begin
				cnt_nz    = 1'b1;
				phase_end = 1'b1;
			end
		endcase
		rd_dig = dig_q[nd_q - NDIG_W'(1)];
		case (cw.src)
			SRC_ZERO:  ch = CH_ZERO;
			SRC_SIGN:  ch = neg_q ? CH_MINUS : CH_PLUS;
			SRC_DIGIT: ch = digit_char(rd_dig);
			default:   ch = CH_SPACE;
		endcase
		can_emit  = !m_valid_q || m_axis_tready;
		active    = (cw.op == OP_EMIT) && en && cnt_nz;
		emit_fire = active && can_emit;
		case (cw.op)
			OP_WAIT: advance = s_fire;
			OP_EMIT: advance = !active || (emit_fire && phase_end);
			default: advance = 1'b1;
		endcase
		case (cw.jmp)
			J_QUOT_NZ: take_jump = (quot != '0);
			J_ALWAYS:  take_jump = 1'b1;
			default:   take_jump = 1'b0;
		endcase
		if (!advance) begin
			pc_next = pc_q;
		end else if (take_jump) begin
			pc_next = cw.target;
		end else begin
			pc_next = pc_q + PC_W'(1);
		end
		wsat = (width_q > 7'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_q);
		len  = CW'(nd_q) + CW'(sign_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= STEP_WAIT;
			nd_q      <= '0;
			cnt_q     <= '0;
			rem_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			case (cw.op)
				OP_WAIT: begin
					if (s_fire) begin
						nd_q <= '0;
					end
				end
				OP_DIV: begin
					nd_q <= nd_q + NDIG_W'(1);
				end
				OP_SETUP: begin
					cnt_q <= (wsat > len) ? wsat - len : '0;
					rem_q <= (wsat > len) ? wsat : len;
				end
				OP_EMIT: begin
					if (emit_fire) begin
						rem_q <= rem_q - CW'(1);
						if (cw.cnt == CNT_PAD) begin
							cnt_q <= cnt_q - CW'(1);
						end
						if (cw.cnt == CNT_DIGITS) begin
							nd_q <= nd_q - NDIG_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
			if (emit_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			neg_q   <= in_val[31];
			mag_q   <= in_val[31] ? (32'd0 - in_val) : in_val;
			radix_q <= s_axis_tdata[33:32];
			width_q <= s_axis_tdata[40:34];
			zpad_q  <= s_axis_tdata[41];
			sign_q  <= in_val[31] || s_axis_tdata[42];
			left_q  <= s_axis_tdata[43];
		end else if (cw.op == OP_DIV) begin
			mag_q <= quot;
		end
		if (cw.op == OP_DIV) begin
			dig_q[nd_q[NDIG_W-1:0]] <= digit;
		end
		if (emit_fire) begin
			m_data_q <= ch;
			m_last_q <= (rem_q == CW'(1));
		end
	end

	`include "assert_macros.svh"

	`ASSERT_CLK(a_idle_all_sent, s_axis_tready |-> (rem_q == '0), "ready with characters owed")
	`ASSERT_NEVER(a_no_extra_char, emit_fire && (rem_q == '0), "character beyond field count")
	`ASSERT_NEVER(a_digit_bound, nd_q > NDIG_W'(NDIG), "digit count overflow")

endmodule
